FILE: sv/dahdsr_pkg.sv
// Shared widths, register indexes and the derived configuration bundle of the envelope generator.
package dahdsr_pkg;

    localparam int unsigned DELAY_TICKS_DEF = 0;
    localparam int unsigned RETRIGGER_DEF   = 0;
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    localparam int LEN_W      = 32;
    localparam int LEVEL_W    = 17;
    localparam int COEF_W     = 24;
    localparam int TRIG_W     = 16;
    localparam int STAGE_W    = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    // Segment bounds are sums of the delay and three lengths and never wrap.
    localparam int BOUND_W    = LEN_W + 2;
    // Wide enough for target*(1-c) + level*c with its sign.
    localparam int BASE_W     = 43;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_LEN    = 4'd0,
        REG_HOLD_LEN      = 4'd1,
        REG_DECAY_LEN     = 4'd2,
        REG_RELEASE_LEN   = 4'd3,
        REG_SUSTAIN_LEVEL = 4'd4,
        REG_ATTACK_COEF   = 4'd5,
        REG_DECAY_COEF    = 4'd6,
        REG_RELEASE_COEF  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                      decay_len_zero;
        logic [LEN_W-1:0]          release_len;
        logic [LEVEL_W-1:0]        sustain;
        logic [COEF_W-1:0]         attack_coef;
        logic [COEF_W-1:0]         decay_coef;
        logic [COEF_W-1:0]         release_coef;
        logic signed [BASE_W-1:0]  attack_base;
        logic signed [BASE_W-1:0]  decay_base;
        logic signed [BASE_W-1:0]  release_base;
        logic [BOUND_W-1:0]        end_attack;
        logic [BOUND_W-1:0]        end_hold;
        logic [BOUND_W-1:0]        end_decay;
    } cfg_t;

endpackage

FILE: sv/dahdsr_cfg.sv
// Configuration registers with precomputed segment bounds and one-pole target products.
module dahdsr_cfg #(
    parameter int unsigned DELAY_TICKS = dahdsr_pkg::DELAY_TICKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dahdsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dahdsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dahdsr_pkg::cfg_t                    cfg
);
    import dahdsr_pkg::*;

    localparam int TGT_W = LEVEL_W + 1;
    localparam logic signed [TGT_W-1:0] ATTACK_TARGET = 18'sd85197;
    localparam logic signed [TGT_W-1:0] SMALL_RATIO   = 18'sd7;
    localparam logic [COEF_W:0]         ONE_Q24       = 25'h1000000;

    // target * (1 - c) in Q.40, registered from the next coefficient and sustain values.
    function automatic logic signed [BASE_W-1:0] pole_base(
        input logic signed [TGT_W-1:0] target,
        input logic [COEF_W-1:0]       coef
    );
        logic [COEF_W:0]          inv;
        logic signed [BASE_W-1:0] t_ext;
        logic signed [BASE_W-1:0] c_ext;
        inv   = ONE_Q24 - {1'b0, coef};
        t_ext = {{(BASE_W-TGT_W){target[TGT_W-1]}}, target};
        c_ext = {{(BASE_W-COEF_W-1){1'b0}}, inv};
        return t_ext * c_ext;
    endfunction

    function automatic logic signed [TGT_W-1:0] decay_target(input logic [LEVEL_W-1:0] sus);
        return $signed({1'b0, sus}) - SMALL_RATIO;
    endfunction

    logic [LEN_W-1:0]   attack_len_reg,  attack_len_next;
    logic [LEN_W-1:0]   hold_len_reg,    hold_len_next;
    logic [LEN_W-1:0]   decay_len_reg,   decay_len_next;
    logic [LEN_W-1:0]   release_len_reg, release_len_next;
    logic [LEVEL_W-1:0] sustain_reg,     sustain_next;
    logic [COEF_W-1:0]  attack_coef_reg, attack_coef_next;
    logic [COEF_W-1:0]  decay_coef_reg,  decay_coef_next;
    logic [COEF_W-1:0]  release_coef_reg, release_coef_next;

    logic signed [BASE_W-1:0] attack_base_reg, decay_base_reg, release_base_reg;
    logic [BOUND_W-1:0]       end_attack_reg, end_hold_reg, end_decay_reg;
    logic [BOUND_W-1:0]       end_attack_next, end_hold_next, end_decay_next;
    logic [LEVEL_W-1:0]       sustain_wr;

    // Values above full scale act as full scale, so they are clipped on the way in.
    assign sustain_wr = (cfg_data[LEVEL_W-1:0] > FULL_LEVEL) ? FULL_LEVEL
                                                             : cfg_data[LEVEL_W-1:0];

    always_comb
    begin
        attack_len_next   = attack_len_reg;
        hold_len_next     = hold_len_reg;
        decay_len_next    = decay_len_reg;
        release_len_next  = release_len_reg;
        sustain_next      = sustain_reg;
        attack_coef_next  = attack_coef_reg;
        decay_coef_next   = decay_coef_reg;
        release_coef_next = release_coef_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ATTACK_LEN:    attack_len_next   = cfg_data[LEN_W-1:0];
                REG_HOLD_LEN:      hold_len_next     = cfg_data[LEN_W-1:0];
                REG_DECAY_LEN:     decay_len_next    = cfg_data[LEN_W-1:0];
                REG_RELEASE_LEN:   release_len_next  = cfg_data[LEN_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_next      = sustain_wr;
                REG_ATTACK_COEF:   attack_coef_next  = cfg_data[COEF_W-1:0];
                REG_DECAY_COEF:    decay_coef_next   = cfg_data[COEF_W-1:0];
                REG_RELEASE_COEF:  release_coef_next = cfg_data[COEF_W-1:0];
                default:           ;
            endcase
        end
        end_attack_next = BOUND_W'(DELAY_TICKS) + BOUND_W'(attack_len_next);
        end_hold_next   = end_attack_next + BOUND_W'(hold_len_next);
        end_decay_next  = end_hold_next + BOUND_W'(decay_len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg   <= '0;
            hold_len_reg     <= '0;
            decay_len_reg    <= '0;
            release_len_reg  <= '0;
            sustain_reg      <= FULL_LEVEL;
            attack_coef_reg  <= '0;
            decay_coef_reg   <= '0;
            release_coef_reg <= '0;
            attack_base_reg  <= pole_base(ATTACK_TARGET, '0);
            decay_base_reg   <= pole_base(decay_target(FULL_LEVEL), '0);
            release_base_reg <= pole_base(-SMALL_RATIO, '0);
            end_attack_reg   <= BOUND_W'(DELAY_TICKS);
            end_hold_reg     <= BOUND_W'(DELAY_TICKS);
            end_decay_reg    <= BOUND_W'(DELAY_TICKS);
        end
        else
        begin
            attack_len_reg   <= attack_len_next;
            hold_len_reg     <= hold_len_next;
            decay_len_reg    <= decay_len_next;
            release_len_reg  <= release_len_next;
            sustain_reg      <= sustain_next;
            attack_coef_reg  <= attack_coef_next;
            decay_coef_reg   <= decay_coef_next;
            release_coef_reg <= release_coef_next;
            attack_base_reg  <= pole_base(ATTACK_TARGET, attack_coef_next);
            decay_base_reg   <= pole_base(decay_target(sustain_next), decay_coef_next);
            release_base_reg <= pole_base(-SMALL_RATIO, release_coef_next);
            end_attack_reg   <= end_attack_next;
            end_hold_reg     <= end_hold_next;
            end_decay_reg    <= end_decay_next;
        end
    end

    always_comb
    begin
        cfg.decay_len_zero = (decay_len_reg == '0);
        cfg.release_len    = release_len_reg;
        cfg.sustain        = sustain_reg;
        cfg.attack_coef    = attack_coef_reg;
        cfg.decay_coef     = decay_coef_reg;
        cfg.release_coef   = release_coef_reg;
        cfg.attack_base    = attack_base_reg;
        cfg.decay_base     = decay_base_reg;
        cfg.release_base   = release_base_reg;
        cfg.end_attack     = end_attack_reg;
        cfg.end_hold       = end_hold_reg;
        cfg.end_decay      = end_decay_reg;
    end

endmodule

FILE: sv/dahdsr_envelope_generator_core.sv
// Envelope generator top level: tick stage with the level recursion, then the output stage.
// An accepted request is registered in the tick stage, then in the output register.
// Throughput: one request per cycle unless output stalls; level recursion is one multiply-add.
// The output register lets one further request enter while a result waits to be taken.
// Reset clears stage, tick count, level, trigger and velocity; sustain resets to full scale.
module dahdsr_envelope_generator_core #(
    parameter int unsigned DELAY_TICKS                 = dahdsr_pkg::DELAY_TICKS_DEF,
    parameter int unsigned RETRIGGER_FROM_SILENCE_ONLY = dahdsr_pkg::RETRIGGER_DEF,
    parameter int unsigned COUNT_WIDTH                 = dahdsr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dahdsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dahdsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dahdsr_pkg::TRIG_W-1:0]       trigger,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dahdsr_pkg::LEVEL_W-1:0]      envelope_out,
    output logic [dahdsr_pkg::STAGE_W-1:0]      stage
);
    import dahdsr_pkg::*;

    localparam int CMP_W  = ((COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W) + 1;
    localparam int ENV_W  = LEVEL_W + TRIG_W + 1;
    localparam int ROUND_SHIFT = COEF_W;
    localparam logic [BASE_W-1:0] POLE_HALF = BASE_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [ENV_W-1:0]  ENV_HALF  = ENV_W'(1) << (TRIG_W - 2);

    localparam logic [STAGE_W-1:0] CODE_SILENT    = 2'd0;
    localparam logic [STAGE_W-1:0] CODE_PLAYING   = 2'd1;
    localparam logic [STAGE_W-1:0] CODE_RELEASING = 2'd2;

    typedef enum logic [2:0] {
        STG_SILENT    = 3'b001,
        STG_PLAYING   = 3'b010,
        STG_RELEASING = 3'b100
    } stage_t;

    // One-pole step: round(base + level*c) to Q1.16, clipped to 0..full scale.
    function automatic logic [LEVEL_W-1:0] one_pole(
        input logic signed [BASE_W-1:0] base,
        input logic [LEVEL_W-1:0]       lvl,
        input logic [COEF_W-1:0]        coef
    );
        logic [BASE_W-1:0]              prod;
        logic signed [BASE_W-1:0]       sum;
        logic [BASE_W-1:0]              rnd;
        logic [BASE_W-ROUND_SHIFT-1:0]  r;
        logic [LEVEL_W-1:0]             res;
        prod = BASE_W'(lvl) * BASE_W'(coef);
        sum  = base + $signed(prod);
        rnd  = $unsigned(sum) + POLE_HALF;
        r    = rnd[BASE_W-1:ROUND_SHIFT];
        if (sum[BASE_W-1])
            res = '0;
        else if (r > (BASE_W-ROUND_SHIFT)'(FULL_LEVEL))
            res = FULL_LEVEL;
        else
            res = r[LEVEL_W-1:0];
        return res;
    endfunction

    cfg_t cfg;

    dahdsr_cfg #(
        .DELAY_TICKS (DELAY_TICKS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Tick stage state; these registers also hold the operands of the output stage.
    stage_t                   stage_reg, stage_next, stage_eff;
    logic [COUNT_WIDTH-1:0]   tick_count_reg, tick_count_next, t;
    logic [COUNT_WIDTH-1:0]   rel_start_reg, rel_start_next;
    logic [LEVEL_W-1:0]       level_reg, level_next, lvl_in, pole_out;
    logic [TRIG_W-1:0]        prev_trig_reg, velocity_reg, velocity_next;
    logic                     a_valid_reg;

    logic                     out_valid_reg;
    logic [LEVEL_W-1:0]       envelope_out_reg;
    logic [STAGE_W-1:0]       stage_out_reg;

    logic                     advance, accept, changed, key_off, key_on, rel_live;
    logic [CMP_W-1:0]         t_ext, rel_end;
    logic signed [BASE_W-1:0] base_sel;
    logic [COEF_W-1:0]        coef_sel;
    logic [ENV_W-1:0]         env_rnd;
    logic [STAGE_W-1:0]       stage_code;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        changed = (trigger != prev_trig_reg);
        key_off = changed && (trigger == '0);
        key_on  = changed && (trigger != '0) &&
                  ((RETRIGGER_FROM_SILENCE_ONLY == 0) || (prev_trig_reg == '0));

        stage_eff      = stage_reg;
        velocity_next  = velocity_reg;
        t              = tick_count_reg;
        rel_start_next = rel_start_reg;
        lvl_in         = level_reg;
        if (key_off)
        begin
            stage_eff      = STG_RELEASING;
            rel_start_next = tick_count_reg;
            if (cfg.decay_len_zero)
                lvl_in = cfg.sustain;
        end
        else if (key_on)
        begin
            stage_eff     = STG_PLAYING;
            velocity_next = trigger;
            t             = '0;
        end

        t_ext    = CMP_W'(t);
        rel_end  = CMP_W'(rel_start_next) + CMP_W'(cfg.release_len);
        rel_live = (t_ext < rel_end);

        // The single one-pole multiplier is shared by attack, decay and release.
        base_sel = cfg.release_base;
        coef_sel = cfg.release_coef;
        if (stage_eff == STG_PLAYING)
        begin
            if (t_ext < CMP_W'(cfg.end_attack))
            begin
                base_sel = cfg.attack_base;
                coef_sel = cfg.attack_coef;
            end
            else
            begin
                base_sel = cfg.decay_base;
                coef_sel = cfg.decay_coef;
            end
        end
        pole_out = one_pole(base_sel, lvl_in, coef_sel);

        stage_next = stage_eff;
        level_next = lvl_in;
        unique case (stage_eff)
            STG_PLAYING:
            begin
                if (t_ext < CMP_W'(DELAY_TICKS))
                    level_next = '0;
                else if (t_ext < CMP_W'(cfg.end_attack))
                    level_next = pole_out;
                else if (t_ext <= CMP_W'(cfg.end_hold))
                    level_next = FULL_LEVEL;
                else if (t_ext <= CMP_W'(cfg.end_decay))
                    level_next = pole_out;
                else
                    level_next = cfg.sustain;
            end
            STG_RELEASING:
            begin
                if (rel_live)
                    level_next = pole_out;
                else
                begin
                    level_next = '0;
                    stage_next = STG_SILENT;
                end
            end
            default:
            begin
                level_next = lvl_in;
            end
        endcase

        tick_count_next = t + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= STG_SILENT;
            tick_count_reg <= '0;
            rel_start_reg  <= '0;
            level_reg      <= '0;
            prev_trig_reg  <= '0;
            velocity_reg   <= '0;
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_reg      <= stage_next;
                tick_count_reg <= tick_count_next;
                rel_start_reg  <= rel_start_next;
                level_reg      <= level_next;
                prev_trig_reg  <= trigger;
                velocity_reg   <= velocity_next;
                a_valid_reg    <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= a_valid_reg;
        end
    end

    // Output stage: level times velocity, rounded back to Q1.16.
    always_comb
    begin
        env_rnd = ENV_W'(level_reg) * ENV_W'(velocity_reg) + ENV_HALF;
        unique case (stage_reg)
            STG_SILENT:    stage_code = CODE_SILENT;
            STG_PLAYING:   stage_code = CODE_PLAYING;
            STG_RELEASING: stage_code = CODE_RELEASING;
            default:       stage_code = CODE_SILENT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            envelope_out_reg <= env_rnd[TRIG_W-1 +: LEVEL_W];
            stage_out_reg    <= stage_code;
        end
    end

    assign out_valid    = out_valid_reg;
    assign envelope_out = envelope_out_reg;
    assign stage        = stage_out_reg;

endmodule
